/* design/name_keyed_entry_table_unit_assert.svh */
// Assertion helpers for the name keyed entry table.
// Both forms are disabled while reset is held.
`ifndef NAME_KEYED_ENTRY_TABLE_UNIT_ASSERT_SVH
`define NAME_KEYED_ENTRY_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NKET_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nket assertion failed");

// Next-cycle implication.
`define NKET_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nket assertion failed");

`endif

/* design/nket_pkg.sv */
`default_nettype none

package nket_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_FIND   = 2'd0;
  localparam kind_t KIND_ADD    = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_PRESENT   = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam int RAW_KEY_W  = 64;
  localparam int IN_SECT_W  = 10;
  localparam int SLOT_W     = 4;

endpackage

`default_nettype wire

/* design/nket_store.sv */
`default_nettype none

// Key and sector storage: one write port, one read port, registered read.
module nket_store #(
  parameter int ENTRIES     = 16,
  parameter int KEY_W       = 64,
  parameter int SECTOR_BITS = 10,
  parameter int IDX_W       = 4
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [IDX_W-1:0]       wr_addr,
  input  wire logic [KEY_W-1:0]       wr_key,
  input  wire logic [SECTOR_BITS-1:0] wr_sector,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output logic      [KEY_W-1:0]       rd_key,
  output logic      [SECTOR_BITS-1:0] rd_sector
);

  logic [KEY_W-1:0]       key_mem    [ENTRIES];
  logic [SECTOR_BITS-1:0] sector_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]    <= wr_key;
      sector_mem[wr_addr] <= wr_sector;
    end
  end

  always_ff @(posedge clk) begin
    rd_key    <= key_mem[rd_addr];
    rd_sector <= sector_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/name_keyed_entry_table_unit.sv */
// Channel  Ports                                        Direction  Moves
// in       in_valid/in_ready, in_kind, in_key_first,    sink       one request transaction
//          in_key_rest, in_new_sector
// out      out_valid/out_ready, out_status,             source     one result transaction
//          out_found_sector, out_slot
//
// Sequence: an accepted request is scanned in S_SCAN, then S_DONE loads its result into
//   the output register once that is free, and in_ready returns with out_valid; one
//   request at a time, the single key comparator walking the store one entry a cycle.
// Reset: rst_n is synchronous, active low; clears the valid marks and control state.
// Stalls: a result waiting on out_ready does not block the next scan; only the
//   next finished result waits for the output register to free up.
`default_nettype none

`include "name_keyed_entry_table_unit_assert.svh"

module name_keyed_entry_table_unit #(
  parameter int ENTRIES     = 16,
  parameter int KEY_BYTES   = 8,
  parameter int SECTOR_BITS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire nket_pkg::kind_t   in_kind,
  input  wire logic [31:0]       in_key_first,
  input  wire logic [31:0]       in_key_rest,
  input  wire logic [9:0]        in_new_sector,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output nket_pkg::status_t      out_status,
  output logic [9:0]             out_found_sector,
  output logic [3:0]             out_slot
);

  import nket_pkg::*;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       scan_cnt_r, scan_cnt_nxt;

  // Request held for the whole scan
  kind_t                  kind_r;
  logic [KEY_W-1:0]       key_r;
  logic [SECTOR_BITS-1:0] sector_r;

  // Compare stage, one entry behind the read address
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;

  // First match and first free slot seen so far
  logic                   hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  logic [SECTOR_BITS-1:0] hit_sector_r, hit_sector_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;

  logic [ENTRIES-1:0]     valid_r, valid_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [9:0]             out_sector_r, out_sector_nxt;
  logic [3:0]             out_slot_r, out_slot_nxt;

  logic                   in_fire;
  logic                   out_fire;
  logic                   out_free;

  // Key canonicalization: name ends at its first zero byte
  logic [RAW_KEY_W-1:0]   raw_key;
  logic [KEY_W-1:0]       canon_key;
  logic                   key_alive;

  logic [SECTOR_BITS+IN_SECT_W-1:0] in_sector_ext;
  logic [SECTOR_BITS+IN_SECT_W-1:0] hit_sector_ext;
  logic [IDX_W+SLOT_W-1:0]          hit_slot_ext;
  logic [IDX_W+SLOT_W-1:0]          free_slot_ext;

  // Storage ports
  logic                   wr_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [KEY_W-1:0]       rd_key;
  logic [SECTOR_BITS-1:0] rd_sector;
  logic                   cmp_match;

  assign raw_key = {in_key_rest, in_key_first};

  always_comb begin
    canon_key = '0;
    key_alive = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw_key[8*b +: 8] == 8'd0) key_alive = 1'b0;
      if (key_alive) canon_key[8*b +: 8] = raw_key[8*b +: 8];
    end
  end

  // Width-neutral sector and slot conversions
  assign in_sector_ext  = {{SECTOR_BITS{1'b0}}, in_new_sector};
  assign hit_sector_ext = {{IN_SECT_W{1'b0}}, hit_sector_r};
  assign hit_slot_ext   = {{SLOT_W{1'b0}}, hit_idx_r};
  assign free_slot_ext  = {{SLOT_W{1'b0}}, free_idx_r};

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_sector = out_sector_r;
  assign out_slot         = out_slot_r;

  assign rd_addr   = scan_cnt_r[IDX_W-1:0];
  assign cmp_match = cmp_vld_r && valid_r[cmp_idx_r] && (rd_key == key_r);
  assign wr_en     = (state_r == S_DONE) && out_free && (kind_r == KIND_ADD)
                     && !hit_found_r && free_found_r;

  nket_store #(
    .ENTRIES     (ENTRIES),
    .KEY_W       (KEY_W),
    .SECTOR_BITS (SECTOR_BITS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (free_idx_r),
    .wr_key    (key_r),
    .wr_sector (sector_r),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_sector (rd_sector)
  );

  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_sector_nxt = hit_sector_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_sector_nxt = out_sector_r;
    out_slot_nxt   = out_slot_r;

    if (out_fire) out_valid_nxt = 1'b0;

    // Compare stage: keep the lowest match and the lowest free slot
    if (cmp_vld_r) begin
      if (cmp_match && !hit_found_r) begin
        hit_found_nxt  = 1'b1;
        hit_idx_nxt    = cmp_idx_r;
        hit_sector_nxt = rd_sector;
      end
      if (!valid_r[cmp_idx_r] && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = cmp_idx_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt      = S_SCAN;
          scan_cnt_nxt   = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == CNT_W'(ENTRIES)) begin
          state_nxt = S_DONE;
        end else begin
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = rd_addr;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          out_sector_nxt = '0;
          out_slot_nxt   = '0;
          unique case (kind_r)
            KIND_FIND: begin
              if (hit_found_r) begin
                out_status_nxt = ST_OK;
                out_sector_nxt = hit_sector_ext[IN_SECT_W-1:0];
                out_slot_nxt   = hit_slot_ext[SLOT_W-1:0];
              end
            end
            KIND_ADD: begin
              if (hit_found_r) begin
                out_status_nxt = ST_PRESENT;
              end else if (free_found_r) begin
                out_status_nxt        = ST_OK;
                out_slot_nxt          = free_slot_ext[SLOT_W-1:0];
                valid_nxt[free_idx_r] = 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            KIND_REMOVE: begin
              if (hit_found_r) begin
                out_status_nxt       = ST_OK;
                out_slot_nxt         = hit_slot_ext[SLOT_W-1:0];
                valid_nxt[hit_idx_r] = 1'b0;
              end
            end
            default: begin
              out_status_nxt = ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_cnt_r   <= '0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_sector_r <= hit_sector_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_sector_r <= out_sector_nxt;
    out_slot_r   <= out_slot_nxt;
    if (in_fire) begin
      kind_r   <= in_kind;
      key_r    <= canon_key;
      sector_r <= in_sector_ext[SECTOR_BITS-1:0];
    end
  end

  // A failed request never reports a slot or a sector.
  `NKET_ASSERT_IMP(a_fail_zero, clk, rst_n,
    out_valid_r && (out_status_r != ST_OK),
    (out_slot_r == 4'd0) && (out_sector_r == 10'd0))
  // Each accepted request starts a fresh scan at entry zero.
  `NKET_ASSERT_NXT(a_scan_start, clk, rst_n, in_fire,
    (state_r == S_SCAN) && (scan_cnt_r == '0) && !hit_found_r && !free_found_r)
  // Compares only happen while scanning.
  `NKET_ASSERT_IMP(a_cmp_in_scan, clk, rst_n, cmp_vld_r, state_r == S_SCAN)
  // A successful add marks exactly one more entry valid.
  `NKET_ASSERT_NXT(a_add_grows, clk, rst_n, wr_en,
    $countones(valid_r) == $past($countones(valid_r)) + 1)

endmodule

`default_nettype wire

/* test/nket_table_checker.sv */
module nket_table_checker #(
  parameter int ENTRIES     = 16,
  parameter int KEY_BYTES   = 8,
  parameter int SECTOR_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  nket_pkg::kind_t     in_kind,
  input  logic [31:0]         in_key_first,
  input  logic [31:0]         in_key_rest,
  input  logic [9:0]          in_new_sector,
  input  logic                out_valid,
  input  logic                out_ready,
  input  nket_pkg::status_t   out_status,
  input  logic [9:0]          out_found_sector,
  input  logic [3:0]          out_slot,
  output int                  fail_count,
  output int                  pending,
  output int                  checked,
  output int                  full_seen
);
  import nket_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [9:0]  sector;
    logic [3:0]  slot;
  } reply_t;

  localparam logic [31:0] SECTOR_MASK = 32'((64'd1 << SECTOR_BITS) - 64'd1);

  // shadow copy of the directory
  logic        entry_live   [ENTRIES];
  logic [63:0] entry_name   [ENTRIES];
  logic [31:0] entry_sector [ENTRIES];

  reply_t replies_due[$];
  reply_t want;
  reply_t got;
  int     fails = 0;
  int     results_checked = 0;
  int     full_cnt = 0;

  // a name ends at its first zero byte; bytes past KEY_BYTES never count
  function automatic logic [63:0] trim_name(input logic [63:0] raw);
    logic [63:0] name;
    name = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= KEY_BYTES || raw[8*b +: 8] == 8'h00) break;
      name[8*b +: 8] = raw[8*b +: 8];
    end
    return name;
  endfunction

  function automatic reply_t resolve_request(input kind_t kind, input logic [63:0] raw,
                                             input logic [9:0] sector_in);
    logic [63:0] name;
    int          hit;
    reply_t      r;
    name     = trim_name(raw);
    hit      = -1;
    r        = '0;
    r.status = ST_NOT_FOUND;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && entry_live[i] && entry_name[i] == name) hit = i;
    end
    case (kind)
      KIND_FIND: begin
        if (hit >= 0) begin
          r.status = ST_OK;
          r.sector = entry_sector[hit][9:0];
          r.slot   = hit[3:0];
        end
      end
      KIND_ADD: begin
        if (hit >= 0) begin
          r.status = ST_PRESENT;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!entry_live[i]) begin
              entry_live[i]   = 1'b1;
              entry_name[i]   = name;
              entry_sector[i] = 32'(sector_in) & SECTOR_MASK;
              r.status        = ST_OK;
              r.slot          = i[3:0];
              break;
            end
          end
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          entry_live[hit] = 1'b0;
          r.status        = ST_OK;
          r.slot          = hit[3:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) entry_live[i] = 1'b0;
      replies_due.delete();
    end else begin
      // retire first: a result never belongs to a request taken at the same edge
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("result transaction with no request outstanding");
          fails++;
        end else begin
          want = replies_due.pop_front();
          results_checked++;
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_found_sector !== want.sector) begin
            $error("found_sector: expected %0d, got %0d", want.sector, out_found_sector);
            fails++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_slot);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got = resolve_request(in_kind, {in_key_rest, in_key_first}, in_new_sector);
        if (got.status == ST_FULL) full_cnt++;
        replies_due.push_back(got);
      end
    end
    fail_count <= fails;
    pending    <= replies_due.size();
    checked    <= results_checked;
    full_seen  <= full_cnt;
  end

endmodule

/* test/tb_name_keyed_entry_table_unit.sv */
module tb_name_keyed_entry_table_unit;
  import nket_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int KEY_BYTES   = 8;
  localparam int SECTOR_BITS = 10;

  // kind 3 has no operation behind it; the block must answer not-found
  localparam kind_t KIND_SPARE = 2'd3;

  localparam int TOTAL_REQUESTS = 1850;
  localparam int POOL_SIZE      = 28;
  // give the tail comfortable room beyond a full scan
  localparam int DRAIN_CYCLES   = 40;
  // longest legit quiet stretch is a sender gap plus a scan plus a receiver stall
  localparam int IDLE_LIMIT     = 2000;

  // how the random phases lean: filling the directory, draining it, or neither
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  kind_t       in_kind       = KIND_FIND;
  logic [31:0] in_key_first  = '0;
  logic [31:0] in_key_rest   = '0;
  logic [9:0]  in_new_sector = '0;
  logic        out_ready     = 1'b0;

  logic        in_ready;
  logic        out_valid;
  status_t     out_status;
  logic [9:0]  out_found_sector;
  logic [3:0]  out_slot;

  int fail_count;
  int pending;
  int checked;
  int full_seen;

  always #5 clk = ~clk;

  name_keyed_entry_table_unit #(
    .ENTRIES    (ENTRIES),
    .KEY_BYTES  (KEY_BYTES),
    .SECTOR_BITS(SECTOR_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_key_first    (in_key_first),
    .in_key_rest     (in_key_rest),
    .in_new_sector   (in_new_sector),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_sector(out_found_sector),
    .out_slot        (out_slot)
  );

  // Passive side: predicts every request and scores every result.
  nket_table_checker #(
    .ENTRIES    (ENTRIES),
    .KEY_BYTES  (KEY_BYTES),
    .SECTOR_BITS(SECTOR_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_key_first    (in_key_first),
    .in_key_rest     (in_key_rest),
    .in_new_sector   (in_new_sector),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_sector(out_found_sector),
    .out_slot        (out_slot),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .full_seen       (full_seen)
  );

  // ---------------------------------------------------------------------------
  // Result side back-pressure. Runs of ready and of stall alternate; most runs
  // are short, some stalls are long enough to back up the scan, and some ready
  // runs are long enough to let the block stream with no stall at all.
  // ---------------------------------------------------------------------------
  int ready_run = 0;

  always @(posedge clk) begin
    if (ready_run == 0) begin
      if (out_ready) begin
        ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        out_ready <= 1'b0;
      end else begin
        ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
        out_ready <= 1'b1;
      end
    end else begin
      ready_run = ready_run - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any cycle with no transaction on either channel counts toward the
  // limit; a hung handshake ends the run as a failure.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("tb_name_keyed_entry_table_unit failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int sent       = 0;
  int sent_by_kind [4] = '{0, 0, 0, 0};

  // Names the random part draws from. More names than slots, so adds both
  // succeed and run into a full directory; finds and removes hit often.
  logic [63:0] name_pool [POOL_SIZE];
  int          name_len  [POOL_SIZE];

  // One request transaction. Requests go out in bursts; when a burst runs out,
  // valid drops for a random gap (sometimes none) before the next one starts.
  task automatic post_request(input kind_t kind, input logic [31:0] first,
                              input logic [31:0] rest, input logic [9:0] sector);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left    = burst_left - 1;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_key_first  <= first;
    in_key_rest   <= rest;
    in_new_sector <= sector;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent = sent + 1;
    sent_by_kind[kind] = sent_by_kind[kind] + 1;
  endtask

  // Pool name as it goes on the wire: half the time the bytes past the
  // terminator carry junk, which must not take part in the match.
  function automatic logic [63:0] dress_name(input int idx);
    logic [63:0] raw;
    raw = name_pool[idx];
    if (name_len[idx] < 7 && $urandom_range(0, 1) == 1) begin
      for (int b = name_len[idx] + 1; b < 8; b++) raw[8*b +: 8] = 8'($urandom_range(0, 255));
    end
    return raw;
  endfunction

  initial begin
    int          phase_left;
    int          roll;
    int          pick;
    int          add_cut;
    int          rem_cut;
    mix_t        mix;
    kind_t       kind;
    logic [63:0] raw;
    logic [9:0]  sector;

    // Pool: the twelve two-byte names the directed fill uses, the empty name,
    // "B", an all-ones name, an alternating-bit name, then random names.
    for (int i = 0; i < 12; i++) begin
      name_pool[i] = {48'h0, 8'(8'h30 + i), 8'h66};
      name_len[i]  = 2;
    end
    name_pool[12] = 64'h0;                     name_len[12] = 0;
    name_pool[13] = 64'h42;                    name_len[13] = 1;
    name_pool[14] = '1;                        name_len[14] = 8;
    name_pool[15] = {32'hAA55_AA55, 32'h55AA_55AA}; name_len[15] = 8;
    for (int i = 16; i < POOL_SIZE; i++) begin
      name_len[i]  = $urandom_range(1, 8);
      name_pool[i] = '0;
      for (int b = 0; b < name_len[i]; b++) name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // empty directory: find and remove both miss; the spare kind answers not-found
    post_request(KIND_FIND, 32'h0000_0000, 32'h0000_0000, 10'd0);
    post_request(KIND_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 10'h3FF);
    post_request(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    // empty name is a legal key and lands in slot 0
    post_request(KIND_ADD, 32'h0000_0000, 32'h0000_0000, 10'd0);
    // "A" with junk after its terminator, then the clean spelling is a duplicate
    post_request(KIND_ADD, 32'hDEAD_0041, 32'hFFFF_FFFF, 10'h3FF);
    post_request(KIND_ADD, 32'h0000_0041, 32'h0000_0000, 10'd5);
    post_request(KIND_FIND, 32'h0000_0041, 32'h1234_5678, 10'd0);
    // full eight-byte names at the bit extremes
    post_request(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h2AA);
    post_request(KIND_ADD, 32'h55AA_55AA, 32'hAA55_AA55, 10'h155);
    // differs from the all-ones name only in the last byte
    post_request(KIND_FIND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 10'd0);
    // fill the rest, then one add too many
    for (int i = 0; i < 12; i++) begin
      post_request(KIND_ADD, name_pool[i][31:0], name_pool[i][63:32],
                   10'($urandom_range(0, 1023)));
    end
    post_request(KIND_ADD, 32'h0000_7A7A, 32'h0000_0000, 10'd1);
    // free a middle slot; the next add must take that lowest hole
    post_request(KIND_REMOVE, 32'h0000_0041, 32'hCAFE_0000, 10'd0);
    post_request(KIND_ADD, 32'h0000_0042, 32'h0000_0000, 10'd77);
    post_request(KIND_FIND, 32'h0000_0000, 32'h8000_0001, 10'd0);

    // ---- random part ----
    // Phases lean toward filling or draining so the directory swings between
    // empty and full. A small share is noise: any kind with any 64-bit key.
    while (sent < TOTAL_REQUESTS) begin
      mix        = mix_t'($urandom_range(0, 2));
      phase_left = $urandom_range(40, 160);
      case (mix)
        MIX_FILL:  begin add_cut = 65; rem_cut = 80; end
        MIX_DRAIN: begin add_cut = 20; rem_cut = 70; end
        default:   begin add_cut = 40; rem_cut = 70; end
      endcase
      while (phase_left > 0 && sent < TOTAL_REQUESTS) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          kind = kind_t'($urandom_range(0, 3));
          raw  = {32'($urandom), 32'($urandom)};
        end else begin
          raw  = dress_name($urandom_range(0, POOL_SIZE - 1));
          pick = $urandom_range(0, 99);
          kind = (pick < add_cut) ? KIND_ADD : (pick < rem_cut) ? KIND_REMOVE : KIND_FIND;
        end
        case ($urandom_range(0, 9))
          0:       sector = 10'd0;
          1:       sector = 10'h3FF;
          default: sector = 10'($urandom_range(0, 1023));
        endcase
        post_request(kind, raw[31:0], raw[63:32], sector);
        phase_left = phase_left - 1;
      end
    end
    in_valid <= 1'b0;

    // pending is registered in the checker, so let one edge pass before trusting it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent: %0d find, %0d add, %0d remove, %0d spare kind",
             sent, sent_by_kind[KIND_FIND], sent_by_kind[KIND_ADD],
             sent_by_kind[KIND_REMOVE], sent_by_kind[KIND_SPARE]);
    $display("%0d results scored, %0d of them directory full", checked, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_name_keyed_entry_table_unit passed");
    end else begin
      $display("tb_name_keyed_entry_table_unit failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/nket_pkg.sv
design/nket_store.sv
design/name_keyed_entry_table_unit.sv
test/nket_table_checker.sv
test/tb_name_keyed_entry_table_unit.sv
